FILE: sv/sawdr_pkg.sv
`default_nettype none
package sawdr_pkg;

   localparam int POS_W              = 11;
   localparam int MAX_PACKET_DEFAULT = 1536;
   localparam int FULL_PAYLOAD_DEFAULT = 1024;
   localparam int QUEUE_DEPTH        = 4;

   // datagram header layout
   localparam logic [POS_W-1:0] POS_KIND     = 11'd0;
   localparam logic [POS_W-1:0] POS_SEQ_HI   = 11'd1;
   localparam logic [POS_W-1:0] POS_SEQ_LO   = 11'd2;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 11'd3;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 11'd4;
   localparam logic [POS_W-1:0] POS_FLAG     = 11'd5;
   localparam logic [POS_W-1:0] PAYLOAD_START = 11'd6;

   localparam logic [7:0]  KIND_DATA  = 8'h04;
   localparam logic [7:0]  FLAG_LAST  = 8'h02;
   localparam logic [15:0] SUM_GOOD   = 16'hFFFF;

   localparam logic       REQ_BYTE    = 1'b0;
   localparam logic       REQ_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      OUT_PAYLOAD = 2'd0,
      OUT_VERDICT = 2'd1,
      OUT_ACK     = 2'd2
   } out_kind_type;

   // result steps of one command, in emission order
   localparam int STEP_COUNT = 8;
   localparam logic [2:0] STEP_PAYLOAD = 3'd0;
   localparam logic [2:0] STEP_VERDICT = 3'd1;
   localparam logic [2:0] STEP_ACK0    = 3'd2;
   localparam logic [2:0] STEP_ACK1    = 3'd3;
   localparam logic [2:0] STEP_ACK2    = 3'd4;
   localparam logic [2:0] STEP_ACK3    = 3'd5;
   localparam logic [2:0] STEP_ACK4    = 3'd6;
   localparam logic [2:0] STEP_ACK5    = 3'd7;

   typedef struct packed {
      logic        has_payload;
      logic        has_verdict;
      logic        has_ack;
      logic [7:0]  payload_byte;
      logic        accepted;
      logic [15:0] commit_length;
      logic        session_complete;
      logic [15:0] ack_seq;
   } cmd_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage
`default_nettype wire

FILE: sv/sawdr_if.sv
`default_nettype none
interface sawdr_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output req_type, output data_byte,
                   output end_of_packet, input ready);
   modport sink   (input valid, input req_type, input data_byte,
                   input end_of_packet, output ready);
endinterface

interface sawdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [7:0]  out_byte;
   logic        accepted;
   logic [15:0] commit_length;
   logic        session_complete;
   logic        ack_last;

   modport source (output valid, output out_kind, output out_byte, output accepted,
                   output commit_length, output session_complete, output ack_last,
                   input ready);
   modport sink   (input valid, input out_kind, input out_byte, input accepted,
                   input commit_length, input session_complete, input ack_last,
                   output ready);
endinterface
`default_nettype wire

FILE: sv/sawdr_front.sv
`default_nettype none
module sawdr_front
   import sawdr_pkg::*;
#(
   parameter int MAX_PACKET_BYTES   = MAX_PACKET_DEFAULT,
   parameter int FULL_PAYLOAD_BYTES = FULL_PAYLOAD_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sawdr_req_if.sink   req_chan,
   output cmd_type     push_cmd,
   output logic        push_valid,
   input  wire logic   push_ready
);

   logic [15:0]      expected_seq_ff, expected_seq_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       pending_ff, pending_in;
   logic [7:0]       kind_ff, kind_in;
   logic [15:0]      hdr_seq_ff, hdr_seq_in;
   logic [15:0]      hdr_len_ff, hdr_len_in;
   logic [7:0]       hdr_flag_ff, hdr_flag_in;
   logic             overlong_ff, overlong_in;
   logic             ack_held_ff, ack_held_in;
   logic [15:0]      held_seq_ff, held_seq_in;
   logic             finished_ff, finished_in;

   logic             fire;
   logic [7:0]       b;
   logic             good;
   logic             last;

   // a finished session swallows everything without queuing
   assign req_chan.ready = finished_ff | push_ready;
   assign fire = req_chan.valid & req_chan.ready & ~finished_ff;
   assign b    = req_chan.data_byte;

   always_comb begin
      expected_seq_in = expected_seq_ff;
      pos_in          = pos_ff;
      sum_in          = sum_ff;
      pending_in      = pending_ff;
      kind_in         = kind_ff;
      hdr_seq_in      = hdr_seq_ff;
      hdr_len_in      = hdr_len_ff;
      hdr_flag_in     = hdr_flag_ff;
      overlong_in     = overlong_ff;
      ack_held_in     = ack_held_ff;
      held_seq_in     = held_seq_ff;
      finished_in     = finished_ff;
      push_cmd        = '0;
      push_valid      = 1'b0;
      good            = 1'b0;
      last            = 1'b0;

      if (fire) begin
         if (req_chan.req_type == REQ_TIMEOUT) begin
            if (ack_held_ff) begin
               push_cmd.has_ack = 1'b1;
               push_cmd.ack_seq = held_seq_ff;
               push_valid       = 1'b1;
            end
         end else begin
            if (pos_ff < POS_W'(MAX_PACKET_BYTES)) begin
               case (pos_ff)
                  POS_KIND: begin
                     kind_in     = b;
                     hdr_seq_in  = '0;
                     hdr_len_in  = '0;
                     hdr_flag_in = '0;
                  end
                  POS_SEQ_HI: hdr_seq_in  = {b, 8'd0};
                  POS_SEQ_LO: hdr_seq_in  = {hdr_seq_ff[15:8], b};
                  POS_LEN_HI: hdr_len_in  = {b, 8'd0};
                  POS_LEN_LO: hdr_len_in  = {hdr_len_ff[15:8], b};
                  POS_FLAG:   hdr_flag_in = b;
                  default: begin
                     push_cmd.has_payload  = 1'b1;
                     push_cmd.payload_byte = b;
                  end
               endcase
               // little-endian words; pad an odd tail with zero
               if (!pos_ff[0]) begin
                  pending_in = b;
                  if (req_chan.end_of_packet) begin
                     sum_in = oc_add(sum_ff, {8'd0, b});
                  end
               end else begin
                  sum_in = oc_add(sum_ff, {b, pending_ff});
               end
               pos_in = pos_ff + POS_W'(1);
            end else begin
               overlong_in = 1'b1;
            end

            if (req_chan.end_of_packet) begin
               push_cmd.has_verdict = 1'b1;
               good = (kind_in == KIND_DATA) && !overlong_in && (sum_in == SUM_GOOD) &&
                      (hdr_seq_in == expected_seq_ff);
               last = (hdr_flag_in == FLAG_LAST);
               if (good) begin
                  push_cmd.accepted         = 1'b1;
                  push_cmd.commit_length    = last ? hdr_len_in : 16'(FULL_PAYLOAD_BYTES);
                  push_cmd.session_complete = last;
                  push_cmd.has_ack          = 1'b1;
                  push_cmd.ack_seq          = expected_seq_ff;
                  held_seq_in               = expected_seq_ff;
                  ack_held_in               = 1'b1;
                  if (last) begin
                     finished_in = 1'b1;
                  end else begin
                     expected_seq_in = expected_seq_ff + 16'd1;
                  end
               end else if (kind_in == KIND_DATA) begin
                  push_cmd.has_ack = ack_held_ff;
                  push_cmd.ack_seq = held_seq_ff;
               end
               pos_in      = '0;
               sum_in      = '0;
               pending_in  = '0;
               overlong_in = 1'b0;
            end
            push_valid = push_cmd.has_payload | push_cmd.has_verdict | push_cmd.has_ack;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_seq_ff <= '0;
         pos_ff          <= '0;
         sum_ff          <= '0;
         pending_ff      <= '0;
         kind_ff         <= '0;
         hdr_seq_ff      <= '0;
         hdr_len_ff      <= '0;
         hdr_flag_ff     <= '0;
         overlong_ff     <= 1'b0;
         ack_held_ff     <= 1'b0;
         held_seq_ff     <= '0;
         finished_ff     <= 1'b0;
      end else begin
         expected_seq_ff <= expected_seq_in;
         pos_ff          <= pos_in;
         sum_ff          <= sum_in;
         pending_ff      <= pending_in;
         kind_ff         <= kind_in;
         hdr_seq_ff      <= hdr_seq_in;
         hdr_len_ff      <= hdr_len_in;
         hdr_flag_ff     <= hdr_flag_in;
         overlong_ff     <= overlong_in;
         ack_held_ff     <= ack_held_in;
         held_seq_ff     <= held_seq_in;
         finished_ff     <= finished_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/sawdr_queue.sv
`default_nettype none
module sawdr_queue
   import sawdr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type push_cmd,
   input  wire logic    push_valid,
   output logic         push_ready,
   output cmd_type      head_cmd,
   output logic         head_valid,
   input  wire logic    pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/sawdr_back.sv
`default_nettype none
module sawdr_back
   import sawdr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type head_cmd,
   input  wire logic    head_valid,
   output logic         pop,
   sawdr_rsp_if.source  rsp_chan
);

   cmd_type                cur_ff, cur_in;
   logic [STEP_COUNT-1:0]  rem_ff, rem_in;
   logic                   out_valid_ff, out_valid_in;
   out_kind_type           out_kind_ff, out_kind_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_acc_ff, out_acc_in;
   logic [15:0]            out_len_ff, out_len_in;
   logic                   out_done_ff, out_done_in;
   logic                   out_last_ff, out_last_in;

   logic                   cur_busy;
   logic                   can_load;
   cmd_type                sel_cmd;
   logic [STEP_COUNT-1:0]  sel_mask;
   logic [2:0]             step;

   assign cur_busy = (rem_ff != '0);
   assign can_load = ~out_valid_ff | rsp_chan.ready;

   always_comb begin
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_acc_in   = out_acc_ff;
      out_len_in   = out_len_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      step         = STEP_PAYLOAD;

      // finish the current command first, else start straight from the queue head
      if (cur_busy) begin
         sel_cmd  = cur_ff;
         sel_mask = rem_ff;
      end else begin
         sel_cmd  = head_cmd;
         sel_mask = head_valid ? {{6{head_cmd.has_ack}}, head_cmd.has_verdict,
                                  head_cmd.has_payload} : '0;
      end

      for (int i = STEP_COUNT - 1; i >= 0; i--) begin
         if (sel_mask[i]) begin
            step = 3'(i);
         end
      end

      if (can_load && sel_mask != '0) begin
         pop          = ~cur_busy;
         cur_in       = sel_cmd;
         rem_in       = sel_mask & ~(STEP_COUNT'(1) << step);
         out_valid_in = 1'b1;
         out_kind_in  = OUT_ACK;
         out_byte_in  = '0;
         out_acc_in   = 1'b0;
         out_len_in   = '0;
         out_done_in  = 1'b0;
         out_last_in  = 1'b0;
         case (step)
            STEP_PAYLOAD: begin
               out_kind_in = OUT_PAYLOAD;
               out_byte_in = sel_cmd.payload_byte;
            end
            STEP_VERDICT: begin
               out_kind_in = OUT_VERDICT;
               out_acc_in  = sel_cmd.accepted;
               out_len_in  = sel_cmd.commit_length;
               out_done_in = sel_cmd.session_complete;
            end
            STEP_ACK0: out_byte_in = '0;
            STEP_ACK1: out_byte_in = sel_cmd.ack_seq[15:8];
            STEP_ACK2: out_byte_in = sel_cmd.ack_seq[7:0];
            STEP_ACK3: out_byte_in = '0;
            // checksum of {0, seq} is just the complement of seq
            STEP_ACK4: out_byte_in = ~sel_cmd.ack_seq[7:0];
            STEP_ACK5: begin
               out_byte_in = ~sel_cmd.ack_seq[15:8];
               out_last_in = 1'b1;
            end
            default: out_byte_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_acc_ff  <= out_acc_in;
      out_len_ff  <= out_len_in;
      out_done_ff <= out_done_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.out_kind         = out_kind_ff;
   assign rsp_chan.out_byte         = out_byte_ff;
   assign rsp_chan.accepted         = out_acc_ff;
   assign rsp_chan.commit_length    = out_len_ff;
   assign rsp_chan.session_complete = out_done_ff;
   assign rsp_chan.ack_last         = out_last_ff;

endmodule
`default_nettype wire

FILE: sv/stop_and_wait_data_receiver.sv
// Stop-and-wait receiver: takes one datagram byte (or a timeout tick) per cycle and returns
// payload bytes, a per-packet verdict and six-byte ACK datagrams on the response channel, one
// result per cycle while that channel is ready. The front stage parses the header and checks the
// checksum as each byte is taken; it stalls only when the four-entry command queue to the
// emitter is full. An end-of-packet byte can yield up to eight results (payload, verdict, six
// ACK bytes), so a burst of such bytes or timeouts runs at the emitter's one-result-per-cycle
// pace; ordinary payload bytes flow at one per cycle while that channel is ready. After an
// accepted last packet every request is taken and dropped until reset.
`default_nettype none
module stop_and_wait_data_receiver
   import sawdr_pkg::*;
#(
   parameter int MAX_PACKET_BYTES   = MAX_PACKET_DEFAULT,
   parameter int FULL_PAYLOAD_BYTES = FULL_PAYLOAD_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sawdr_req_if.sink   req_chan,
   sawdr_rsp_if.source rsp_chan
);

   cmd_type push_cmd;
   logic    push_valid;
   logic    push_ready;
   cmd_type head_cmd;
   logic    head_valid;
   logic    pop;

   sawdr_front #(
      .MAX_PACKET_BYTES   (MAX_PACKET_BYTES),
      .FULL_PAYLOAD_BYTES (FULL_PAYLOAD_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   sawdr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .pop        (pop)
   );

   sawdr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
`default_nettype wire

FILE: tb/tb_stop_and_wait_data_receiver.sv
`timescale 1ns / 1ps
module tb_stop_and_wait_data_receiver;
   import sawdr_pkg::*;

   localparam int RANDOM_ITEMS  = 340;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 64;
   localparam int USE_PREDICTOR = -1;
   localparam logic [15:0] FULL_COMMIT = 16'(FULL_PAYLOAD_DEFAULT);

   typedef struct packed {
      out_kind_type kind;
      logic [7:0]   data;
      logic         accepted;
      logic [15:0]  commit_length;
      logic         session_complete;
      logic         ack_last;
   } rx_out_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       eop;
      int         typed_count;
      rx_out_type typed_out;
   } stim_row_type;

   logic clock;
   logic reset;

   sawdr_req_if req_chan ();
   sawdr_rsp_if rsp_chan ();

   stop_and_wait_data_receiver dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rx_out_type   arq_out_due[$];
   rx_out_type   arq_step_out[$];
   stim_row_type stim_table[$];
   logic [7:0]   frame[$];
   int           mismatches = 0;
   bit           idle_enable = 1'b0;
   bit           stall_enable = 1'b0;
   bit           hold_rsp = 1'b0;

   // receiver state as the block should hold it
   logic [15:0]      exp_seq = '0;
   logic [POS_W-1:0] rx_pos = '0;
   logic [15:0]      rx_sum = '0;
   logic [7:0]       rx_low = '0;
   logic [7:0]       rx_kind = '0;
   logic [15:0]      rx_hdr_seq = '0;
   logic [15:0]      rx_hdr_len = '0;
   logic [7:0]       rx_hdr_flag = '0;
   logic             rx_overlong = 1'b0;
   logic             ack_valid = 1'b0;
   logic [15:0]      ack_seq = '0;
   logic             session_over = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic rx_out_type payload_out(input logic [7:0] b);
      rx_out_type r;
      r = '0;
      r.kind = OUT_PAYLOAD;
      r.data = b;
      return r;
   endfunction

   function automatic rx_out_type verdict_out(input logic acc, input logic [15:0] len,
                                              input logic done);
      rx_out_type r;
      r = '0;
      r.kind = OUT_VERDICT;
      r.accepted = acc;
      r.commit_length = len;
      r.session_complete = done;
      return r;
   endfunction

   function automatic void arq_push_ack();
      logic [15:0] cks;
      logic [47:0] ack_bytes;
      rx_out_type  r;
      cks = ~ones_add({ack_seq[15:8], 8'h00}, {8'h00, ack_seq[7:0]});
      ack_bytes = {8'h00, ack_seq[15:8], ack_seq[7:0], 8'h00, cks[7:0], cks[15:8]};
      for (int i = 0; i < 6; i++) begin
         r = '0;
         r.kind = OUT_ACK;
         r.data = ack_bytes[47 - 8 * i -: 8];
         r.ack_last = (i == 5);
         arq_step_out.push_back(r);
      end
   endfunction

   // work out the results of one request and advance the receiver state
   function automatic void arq_step(input logic req_type, input logic [7:0] b,
                                    input logic eop);
      logic last;
      arq_step_out.delete();
      if (session_over)
         return;
      if (req_type == REQ_TIMEOUT) begin
         if (ack_valid)
            arq_push_ack();
         return;
      end
      if (rx_pos < MAX_PACKET_DEFAULT) begin
         case (rx_pos)
            POS_KIND: begin
               rx_kind = b;
               rx_hdr_seq = '0;
               rx_hdr_len = '0;
               rx_hdr_flag = '0;
            end
            POS_SEQ_HI: rx_hdr_seq = {b, 8'h00};
            POS_SEQ_LO: rx_hdr_seq = rx_hdr_seq | {8'h00, b};
            POS_LEN_HI: rx_hdr_len = {b, 8'h00};
            POS_LEN_LO: rx_hdr_len = rx_hdr_len | {8'h00, b};
            POS_FLAG:   rx_hdr_flag = b;
            default:    arq_step_out.push_back(payload_out(b));
         endcase
         if (!rx_pos[0]) begin
            rx_low = b;
            // odd length: pad the last word with zero
            if (eop)
               rx_sum = ones_add(rx_sum, {8'h00, b});
         end else begin
            rx_sum = ones_add(rx_sum, {b, rx_low});
         end
         rx_pos = rx_pos + POS_W'(1);
      end else begin
         rx_overlong = 1'b1;
      end
      if (eop) begin
         if (rx_kind != KIND_DATA) begin
            arq_step_out.push_back(verdict_out(1'b0, 16'd0, 1'b0));
         end else if (!rx_overlong && rx_sum == SUM_GOOD && rx_hdr_seq == exp_seq) begin
            last = (rx_hdr_flag == FLAG_LAST);
            arq_step_out.push_back(verdict_out(1'b1, last ? rx_hdr_len : FULL_COMMIT, last));
            ack_seq = exp_seq;
            ack_valid = 1'b1;
            arq_push_ack();
            if (last)
               session_over = 1'b1;
            else
               exp_seq = exp_seq + 16'd1;
         end else begin
            arq_step_out.push_back(verdict_out(1'b0, 16'd0, 1'b0));
            if (ack_valid)
               arq_push_ack();
         end
         rx_pos = '0;
         rx_sum = '0;
         rx_low = '0;
         rx_overlong = 1'b0;
      end
   endfunction

   function automatic void add_row(input logic req_type, input logic [7:0] b, input logic eop,
                                   input int typed_count, input rx_out_type typed_out);
      stim_row_type row;
      row.req_type = req_type;
      row.data_byte = b;
      row.eop = eop;
      row.typed_count = typed_count;
      row.typed_out = typed_out;
      stim_table.push_back(row);
   endfunction

   function automatic logic [7:0] pick_flag();
      logic [7:0] f;
      f = rand_byte();
      return (f == FLAG_LAST) ? 8'h00 : f;
   endfunction

   // data packet with a valid checksum carried in the first two payload bytes
   function automatic void build_data_frame(input logic [15:0] seq, input logic [7:0] flag,
                                            input int payload_len);
      logic [15:0] len_field;
      logic [15:0] sum;
      logic [7:0]  hi;
      len_field = 16'($urandom_range(0, 65535));
      frame.delete();
      frame.push_back(KIND_DATA);
      frame.push_back(seq[15:8]);
      frame.push_back(seq[7:0]);
      frame.push_back(len_field[15:8]);
      frame.push_back(len_field[7:0]);
      frame.push_back(flag);
      for (int i = 0; i < payload_len; i++)
         frame.push_back(rand_byte());
      frame[PAYLOAD_START] = 8'h00;
      frame[PAYLOAD_START + 1] = 8'h00;
      sum = '0;
      // bytes past the size limit never enter the sum
      for (int i = 0; i < frame.size() && i < MAX_PACKET_DEFAULT; i += 2) begin
         hi = (i + 1 < frame.size()) ? frame[i + 1] : 8'h00;
         sum = ones_add(sum, {hi, frame[i]});
      end
      sum = ~sum;
      frame[PAYLOAD_START] = sum[7:0];
      frame[PAYLOAD_START + 1] = sum[15:8];
   endfunction

   function automatic void build_noise_frame(input int len);
      frame.delete();
      for (int i = 0; i < len; i++)
         frame.push_back(rand_byte());
   endfunction

   task automatic send_item(input logic req_type, input logic [7:0] b, input logic eop,
                            input int typed_count, input rx_out_type typed_out);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= req_type;
      req_chan.data_byte <= b;
      req_chan.end_of_packet <= eop;
      arq_step(req_type, b, eop);
      if (typed_count == USE_PREDICTOR) begin
         foreach (arq_step_out[i])
            arq_out_due.push_back(arq_step_out[i]);
      end else if (typed_count > 0) begin
         arq_out_due.push_back(typed_out);
      end
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic send_timeout();
      send_item(REQ_TIMEOUT, rand_byte(), 1'($urandom_range(0, 1)), USE_PREDICTOR, '0);
   endtask

   // timeouts may land in the middle of a datagram
   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         if (i > 0 && $urandom_range(0, 39) == 0)
            send_timeout();
         send_item(REQ_BYTE, frame[i], i == frame.size() - 1, USE_PREDICTOR, '0);
      end
   endtask

   function automatic int pick_payload_len();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(2, 24);
   endfunction

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      rx_out_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (arq_out_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got kind %0d byte %0h",
                     $time, rsp_chan.out_kind, rsp_chan.out_byte);
         end else begin
            want = arq_out_due.pop_front();
            check_field("out_kind", 16'(want.kind), 16'(rsp_chan.out_kind));
            check_field("out_byte", 16'(want.data), 16'(rsp_chan.out_byte));
            check_field("accepted", 16'(want.accepted), 16'(rsp_chan.accepted));
            check_field("commit_length", want.commit_length, rsp_chan.commit_length);
            check_field("session_complete", 16'(want.session_complete),
                        16'(rsp_chan.session_complete));
            check_field("ack_last", 16'(want.ack_last), 16'(rsp_chan.ack_last));
         end
      end
   end

   initial begin : stimulus
      int  sent;
      int  pkt;
      int  idx;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.req_type <= REQ_BYTE;
      req_chan.data_byte <= 8'h00;
      req_chan.end_of_packet <= 1'b0;

      // nothing to resend before the first ack
      add_row(REQ_TIMEOUT, 8'hA5, 1'b1, 0, '0);
      add_row(REQ_BYTE, 8'hFF, 1'b1, 1, verdict_out(1'b0, 16'd0, 1'b0));
      // truncated data header
      add_row(REQ_BYTE, 8'h04, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b1, 1, verdict_out(1'b0, 16'd0, 1'b0));
      // short good packet, sequence 0, length field all ones
      add_row(REQ_BYTE, 8'h04, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'hFF, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'hFF, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'hFB, 1'b0, 1, payload_out(8'hFB));
      add_row(REQ_BYTE, 8'hFF, 1'b1, USE_PREDICTOR, '0);
      add_row(REQ_TIMEOUT, 8'h00, 1'b0, USE_PREDICTOR, '0);
      // duplicate of the same packet, with a timeout inside it
      add_row(REQ_BYTE, 8'h04, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_TIMEOUT, 8'hFF, 1'b1, USE_PREDICTOR, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'hFF, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'hFF, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'hFB, 1'b0, 1, payload_out(8'hFB));
      add_row(REQ_BYTE, 8'hFF, 1'b1, USE_PREDICTOR, '0);
      // odd-length runt: padded sum fails
      add_row(REQ_BYTE, 8'h04, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h00, 1'b0, 0, '0);
      add_row(REQ_BYTE, 8'h01, 1'b1, USE_PREDICTOR, '0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idle_enable = 1'b1;
      stall_enable = 1'b1;

      foreach (stim_table[i])
         send_item(stim_table[i].req_type, stim_table[i].data_byte, stim_table[i].eop,
                   stim_table[i].typed_count, stim_table[i].typed_out);

      sent = 0;
      for (pkt = 0; sent < RANDOM_ITEMS; pkt++) begin
         idle_enable = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         // stall the output while requests keep coming
         if (pkt == 6)
            hold_rsp = 1'b1;
         if ($urandom_range(0, 6) == 0) begin
            send_timeout();
            sent++;
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
               build_data_frame(exp_seq, pick_flag(), pick_payload_len());
            10, 11:
               build_data_frame($urandom_range(0, 1) ? exp_seq - 16'd1
                                   : exp_seq + 16'($urandom_range(1, 65535)),
                                $urandom_range(0, 1) ? FLAG_LAST : pick_flag(),
                                pick_payload_len());
            12, 13: begin
               build_data_frame(exp_seq, $urandom_range(0, 1) ? FLAG_LAST : pick_flag(),
                                pick_payload_len());
               idx = $urandom_range(0, frame.size() - 1);
               frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            14, 15: begin
               build_data_frame(16'($urandom_range(0, 65535)), rand_byte(),
                                pick_payload_len());
               frame[POS_KIND] = rand_byte();
               if (frame[POS_KIND] == KIND_DATA)
                  frame[POS_KIND] = 8'h00;
            end
            16, 17: begin
               build_noise_frame($urandom_range(1, 7));
               if ($urandom_range(0, 1) == 0)
                  frame[POS_KIND] = KIND_DATA;
            end
            default: build_noise_frame($urandom_range(1, 30));
         endcase
         send_frame();
         sent += frame.size();
      end

      idle_enable = 1'b0;
      stall_enable = 1'b0;
      repeat (3) begin
         build_data_frame(exp_seq, pick_flag(), pick_payload_len());
         send_frame();
      end
      // close the session; everything after it is dropped
      build_data_frame(exp_seq, FLAG_LAST, pick_payload_len());
      send_frame();
      send_timeout();
      build_noise_frame($urandom_range(1, 10));
      send_frame();
      req_chan.valid <= 1'b0;

      while (arq_out_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && arq_out_due.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
